// ----- src/shape_table_collision_query_macros.svh -----
// Assertion macros shared by the shape table checker.
`ifndef SHAPE_TABLE_COLLISION_QUERY_MACROS_SVH
`define SHAPE_TABLE_COLLISION_QUERY_MACROS_SVH

// Assert a property on a given clock and active-low reset.
`define STCQ_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error(msg);

// Assert a property on clk and arst_n.
`define STCQ_ASSERT_CLK(lbl, prop, msg) `STCQ_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ----- src/stcq_pkg.sv -----
// Types, constants and helper functions for the shape table collision query block.
package stcq_pkg;

	localparam int SW         = 35;
	localparam int MAGW       = 33;
	localparam int PARTW      = 17;
	localparam int ACCW       = 67;
	localparam int SQ_STEPS   = 6;
	localparam int IN_DATA_W  = 144;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 1;

	typedef logic signed [SW-1:0] sval_t;

	localparam sval_t S32_MAX = sval_t'(64'sd2147483647);
	localparam sval_t S32_MIN = sval_t'(-64'sd2147483648);
	localparam sval_t W31_MAX = sval_t'(64'sd2147483647);

	localparam logic [1:0] KIND_EMPTY  = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_RECT   = 2'd2;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_DELETE,
		CMD_OVERLAP,
		CMD_CONTAINS
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_DELETE,
		ST_READ_A,
		ST_READ_B,
		ST_CAP_B,
		ST_CALC1,
		ST_CALC2,
		ST_SQ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        w;
		logic [30:0]        h;
	} entry_t;

	typedef struct packed {
		logic            status;
		logic            hit;
		logic            use_sq;
		sval_t           dx;
		sval_t           dy;
		logic [MAGW-1:0] rad;
		sval_t           ox;
		sval_t           oy;
		sval_t           x0;
		sval_t           x1;
		sval_t           y0;
		sval_t           y1;
	} geom_t;

	function automatic logic signed [31:0] sat32(input sval_t v);
		if (v > S32_MAX) begin
			return 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			return 32'sh80000000;
		end
		return $signed(v[31:0]);
	endfunction

	function automatic logic [30:0] satw(input sval_t v);
		if (v < 0) begin
			return '0;
		end else if (v > W31_MAX) begin
			return '1;
		end
		return v[30:0];
	endfunction

endpackage

// ----- src/stcq_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module stcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/stcq_sqacc.sv -----
// Shared square-and-accumulate unit deciding dx^2 + dy^2 <= rad^2.
module stcq_sqacc
	import stcq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sval_t           dx,
	input  sval_t           dy,
	input  logic [MAGW-1:0] rad,
	output logic            done,
	output logic            le
);

	logic [MAGW-1:0]       op_q [3];
	logic                  active_q;
	logic [2:0]            step_q;
	logic                  pv_s1;
	logic                  last_s1;
	logic                  rsq_s1;
	logic                  done_q;
	logic [ACCW-1:0]       prod_s1;
	logic [ACCW-1:0]       sum_q;
	logic [ACCW-1:0]       rsq_q;
	logic [MAGW-1:0]       op_w;
	logic [PARTW-1:0]      part_w;
	logic [MAGW+PARTW-1:0] mul_w;
	logic                  last_w;

	function automatic logic [MAGW-1:0] mag(input sval_t v);
		sval_t n;
		n = v[SW-1] ? -v : v;
		return n[MAGW-1:0];
	endfunction

	always_comb begin
		op_w   = op_q[step_q[2:1]];
		part_w = step_q[0] ? PARTW'(op_w[MAGW-1:PARTW]) : op_w[PARTW-1:0];
		mul_w  = op_w * part_w;
		last_w = (step_q == 3'(SQ_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			pv_s1    <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			pv_s1   <= active_q;
			last_s1 <= active_q && last_w;
			done_q  <= pv_s1 && last_s1;
			if (start) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				step_q <= step_q + 3'd1;
				if (last_w) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q[0] <= mag(dx);
			op_q[1] <= mag(dy);
			op_q[2] <= rad;
			sum_q   <= '0;
			rsq_q   <= '0;
		end else if (pv_s1) begin
			if (rsq_s1) begin
				rsq_q <= rsq_q + prod_s1;
			end else begin
				sum_q <= sum_q + prod_s1;
			end
		end
		if (active_q) begin
			prod_s1 <= step_q[0] ? {mul_w, {PARTW{1'b0}}} : ACCW'(mul_w);
			rsq_s1  <= step_q[2];
		end
	end

	assign done = done_q;
	assign le   = (sum_q <= rsq_q);

endmodule

// ----- src/stcq_geom.sv -----
// Shape geometry: extents, joint box, centre, direct hit tests and operands for the squarer.
module stcq_geom
	import stcq_pkg::*;
(
	input  cmd_t               cmd,
	input  logic               a_live,
	input  logic               b_live,
	input  entry_t             ent_a,
	input  entry_t             ent_b,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	output geom_t              geo
);

	sval_t xa, ya, wa, ha, xb, yb, wb, hb, pxs, pys;
	sval_t ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
	sval_t cxv, cyv, rx0, rx1, ry0, ry1, nx, ny;
	logic  a_rect, b_rect;
	logic [MAGW-1:0] rc_rad;

	always_comb begin
		xa  = SW'(ent_a.x);
		ya  = SW'(ent_a.y);
		wa  = SW'(ent_a.w);
		ha  = SW'(ent_a.h);
		xb  = SW'(ent_b.x);
		yb  = SW'(ent_b.y);
		wb  = SW'(ent_b.w);
		hb  = SW'(ent_b.h);
		pxs = SW'(px);
		pys = SW'(py);
		a_rect = (ent_a.kind == KIND_RECT);
		b_rect = (ent_b.kind == KIND_RECT);

		ax0 = a_rect ? xa : xa - wa;
		ax1 = xa + wa;
		ay0 = a_rect ? ya : ya - wa;
		ay1 = a_rect ? ya + ha : ya + wa;
		bx0 = b_rect ? xb : xb - wb;
		bx1 = xb + wb;
		by0 = b_rect ? yb : yb - wb;
		by1 = b_rect ? yb + hb : yb + wb;

		cxv    = a_rect ? xb : xa;
		cyv    = a_rect ? yb : ya;
		rc_rad = a_rect ? MAGW'(ent_b.w) : MAGW'(ent_a.w);
		rx0    = a_rect ? ax0 : bx0;
		rx1    = a_rect ? ax1 : bx1;
		ry0    = a_rect ? ay0 : by0;
		ry1    = a_rect ? ay1 : by1;
		nx     = (cxv < rx0) ? rx0 : ((cxv > rx1) ? rx1 : cxv);
		ny     = (cyv < ry0) ? ry0 : ((cyv > ry1) ? ry1 : cyv);

		geo = '0;
		case (cmd)
			CMD_OVERLAP: begin
				if (!(a_live && b_live)) begin
					geo.status = 1'b1;
				end else begin
					geo.ox = (bx0 < ax0) ? bx0 : ax0;
					geo.oy = (by0 < ay0) ? by0 : ay0;
					geo.x0 = geo.ox;
					geo.y0 = geo.oy;
					geo.x1 = (bx1 > ax1) ? bx1 : ax1;
					geo.y1 = (by1 > ay1) ? by1 : ay1;
					if (a_rect && b_rect) begin
						geo.hit = (ax0 <= bx1) && (bx0 <= ax1) && (ay0 <= by1) && (by0 <= ay1);
					end else if (!a_rect && !b_rect) begin
						geo.use_sq = 1'b1;
						geo.dx     = xa - xb;
						geo.dy     = ya - yb;
						geo.rad    = MAGW'(ent_a.w) + MAGW'(ent_b.w);
					end else begin
						geo.use_sq = 1'b1;
						geo.dx     = cxv - nx;
						geo.dy     = cyv - ny;
						geo.rad    = rc_rad;
					end
				end
			end
			CMD_CONTAINS: begin
				if (!a_live) begin
					geo.status = 1'b1;
				end else if (a_rect) begin
					geo.hit = (xa <= pxs) && (pxs <= ax1) && (ya <= pys) && (pys <= ay1);
					geo.ox  = xa + SW'(ent_a.w[30:1]);
					geo.oy  = ya + SW'(ent_a.h[30:1]);
				end else begin
					geo.use_sq = 1'b1;
					geo.dx     = xa - pxs;
					geo.dy     = ya - pys;
					geo.rad    = MAGW'(ent_a.w);
					geo.ox     = xa;
					geo.oy     = ya;
				end
			end
			default: begin
				geo = '0;
			end
		endcase
	end

endmodule

// ----- src/shape_table_collision_query.sv -----
// Top level of the shape table with rectangle and circle collision queries.
// Holds ENTRIES shapes (circle or rectangle, Q16.16) in one synchronous RAM of one 128-bit word
// per id and serves one command at a time. After reset the block sweeps the table, one entry
// per cycle, with s_axis_tready low. A write passes through a write state, a delete makes one
// RAM write per id in its range, and a query reads both entries, registers the geometry and
// decides its outcome from compares alone for a rectangle pair or a point in a rectangle.
// Queries that involve a circle also pass through the shared squarer, which builds each 66-bit
// square from two 33x17 partial products. The result leaves through an output register, so the
// next command is taken while a result still waits on m_axis_tready.
module shape_table_collision_query
	import stcq_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // id_a, id_b, px, py, pw, ph, zero pad
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // cmd, shape_kind
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // hit, out_x, out_y, out_w, out_h, zero pad
	output logic [OUT_USER_W-1:0] m_axis_tuser   // status
);

	localparam int AW = $clog2(ENTRIES);

	state_t             state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [7:0]         del_q, del_hi_q;
	cmd_t               cmd_q;
	logic [7:0]         id_a_q, id_b_q;
	logic               kind_q;
	logic signed [31:0] px_q, py_q;
	logic [30:0]        pw_q, ph_q;
	entry_t             ent_a_q, ent_b_q, wr_entry, rd_entry;
	geom_t              geo_w, geo_q;
	logic               res_status_q, res_hit_q;
	logic signed [31:0] res_x_q, res_y_q;
	logic [30:0]        res_w_q, res_h_q;
	logic               out_valid_q, out_status_q, out_hit_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic [30:0]        out_w_q, out_h_q;
	logic               ram_we, sq_start, sq_done, sq_le, out_load, accept;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic               a_live, b_live;
	cmd_t               in_cmd;
	logic [7:0]         in_id_a, in_id_b;

	function automatic logic id_ok(input logic [7:0] id);
		return 32'(id) < ENTRIES;
	endfunction

	assign in_cmd  = cmd_t'(s_axis_tuser[1:0]);
	assign in_id_a = s_axis_tdata[7:0];
	assign in_id_b = s_axis_tdata[15:8];
	assign accept  = s_axis_tvalid && s_axis_tready;

	assign wr_entry.kind = kind_q ? KIND_RECT : KIND_CIRCLE;
	assign wr_entry.x    = px_q;
	assign wr_entry.y    = py_q;
	assign wr_entry.w    = pw_q;
	assign wr_entry.h    = kind_q ? ph_q : '0;

	stcq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (state_q == ST_WRITE ? wr_entry : entry_t'('0)),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	assign a_live = id_ok(id_a_q) && (ent_a_q.kind != KIND_EMPTY);
	assign b_live = id_ok(id_b_q) && (ent_b_q.kind != KIND_EMPTY);

	stcq_geom u_geom (
		.cmd    (cmd_q),
		.a_live (a_live),
		.b_live (b_live),
		.ent_a  (ent_a_q),
		.ent_b  (ent_b_q),
		.px     (px_q),
		.py     (py_q),
		.geo    (geo_w)
	);

	stcq_sqacc u_sqacc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.dx     (geo_q.dx),
		.dy     (geo_q.dy),
		.rad    (geo_q.rad),
		.done   (sq_done),
		.le     (sq_le)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			del_q       <= '0;
			del_hi_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				del_q    <= (in_id_a < in_id_b) ? in_id_a : in_id_b;
				del_hi_q <= (in_id_a < in_id_b) ? in_id_b : in_id_a;
			end else if (state_q == ST_DELETE) begin
				del_q <= del_q + 8'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = AW'(id_a_q);
		ram_raddr     = AW'(id_a_q);
		sq_start      = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == AW'(ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (in_cmd)
						CMD_WRITE:  state_d = ST_WRITE;
						CMD_DELETE: state_d = ST_DELETE;
						default:    state_d = ST_READ_A;
					endcase
				end
			end
			ST_WRITE: begin
				ram_we  = id_ok(id_a_q);
				state_d = ST_DONE;
			end
			ST_DELETE: begin
				ram_we    = id_ok(del_q);
				ram_waddr = AW'(del_q);
				if (del_q == del_hi_q) begin
					state_d = ST_DONE;
				end
			end
			ST_READ_A: begin
				state_d = ST_READ_B;
			end
			ST_READ_B: begin
				ram_raddr = AW'(id_b_q);
				state_d   = ST_CAP_B;
			end
			ST_CAP_B: begin
				state_d = ST_CALC1;
			end
			ST_CALC1: begin
				state_d = ST_CALC2;
			end
			ST_CALC2: begin
				if (geo_q.use_sq) begin
					sq_start = 1'b1;
					state_d  = ST_SQ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SQ: begin
				if (sq_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= in_cmd;
			id_a_q       <= in_id_a;
			id_b_q       <= in_id_b;
			kind_q       <= s_axis_tuser[2];
			px_q         <= $signed(s_axis_tdata[47:16]);
			py_q         <= $signed(s_axis_tdata[79:48]);
			pw_q         <= s_axis_tdata[110:80];
			ph_q         <= s_axis_tdata[141:111];
			res_status_q <= 1'b0;
			res_hit_q    <= 1'b0;
			res_x_q      <= '0;
			res_y_q      <= '0;
			res_w_q      <= '0;
			res_h_q      <= '0;
		end
		if (state_q == ST_READ_B) begin
			ent_a_q <= rd_entry;
		end
		if (state_q == ST_CAP_B) begin
			ent_b_q <= rd_entry;
		end
		if (state_q == ST_CALC1) begin
			geo_q <= geo_w;
		end
		if (state_q == ST_CALC2) begin
			res_status_q <= geo_q.status;
			res_hit_q    <= geo_q.hit;
			res_x_q      <= sat32(geo_q.ox);
			res_y_q      <= sat32(geo_q.oy);
			res_w_q      <= satw(geo_q.x1 - geo_q.x0);
			res_h_q      <= satw(geo_q.y1 - geo_q.y0);
		end
		if (state_q == ST_SQ && sq_done) begin
			res_hit_q <= sq_le;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_hit_q    <= res_hit_q;
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
			out_w_q      <= res_w_q;
			out_h_q      <= res_h_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_h_q, out_w_q, out_y_q, out_x_q, out_hit_q};
	assign m_axis_tuser  = out_status_q;

endmodule

// ----- src/stcq_checker.sv -----
// Port-level checker for the shape table collision query block, bound to the top level.
`include "shape_table_collision_query_macros.svh"

module stcq_checker
	import stcq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	logic                             in_take;
	logic                             out_wait;
	logic                             out_empty;
	logic [OUT_USER_W+OUT_DATA_W-1:0] out_word;

	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign out_wait  = m_axis_tvalid && !m_axis_tready;
	assign out_empty = m_axis_tvalid && m_axis_tuser[0];
	assign out_word  = {m_axis_tuser, m_axis_tdata};

	`STCQ_ASSERT_CLK(a_out_hold, out_wait |=> m_axis_tvalid, "stalled result dropped")
	`STCQ_ASSERT_CLK(a_out_stable, out_wait |=> $stable(out_word), "stalled result changed")
	`STCQ_ASSERT_CLK(a_empty_zero, out_empty |-> m_axis_tdata == '0, "empty result has data")
	`STCQ_ASSERT_CLK(a_one_at_time, in_take |=> !s_axis_tready, "command taken while busy")

endmodule

bind shape_table_collision_query stcq_checker u_stcq_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the shape table collision query block.
`timescale 1ns / 100ps

module tb;
	import stcq_pkg::*;

	localparam int NUM_IDS      = 256;
	localparam int RANDOM_CMDS  = 1850;
	localparam int CALM_TAIL    = 200;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 600;
	localparam longint SAT_HI   = 64'sd2147483647;
	localparam longint SAT_LO   = -64'sd2147483648;
	localparam longint SIZE_MAX = 64'sd2147483647;

	typedef struct {
		cmd_t               cmd;
		logic [7:0]         id_a;
		logic [7:0]         id_b;
		logic               kind;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [30:0]        pw;
		logic [30:0]        ph;
	} shape_cmd_t;

	typedef struct {
		logic               status;
		logic               hit;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic [30:0]        ow;
		logic [30:0]        oh;
	} query_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	shape_table_collision_query #(.ENTRIES(NUM_IDS)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	logic [1:0] tbl_kind [NUM_IDS];
	longint     tbl_x    [NUM_IDS];
	longint     tbl_y    [NUM_IDS];
	longint     tbl_w    [NUM_IDS];
	longint     tbl_h    [NUM_IDS];

	shape_cmd_t pending_cmds[$];
	query_res_t expected_responses[$];
	shape_cmd_t cur_cmd;
	query_res_t mon_got;
	query_res_t mon_want;

	int   total_cmds = 0;
	int   sent_cnt = 0;
	int   rcv_cnt = 0;
	int   err_cnt = 0;
	int   gap_cnt = 0;
	int   stall_cnt = 0;
	int   src_idle_pct = 10;
	int   sink_idle_pct = 10;
	logic hold_rx = 1'b0;
	logic nxt_ready;

	function automatic longint absv(input longint d);
		return d < 0 ? -d : d;
	endfunction

	function automatic logic [69:0] square(input longint m);
		logic [69:0] a;
		a = 70'(m);
		return a * a;
	endfunction

	function automatic logic in_radius(input longint dx, input longint dy, input longint rad);
		return (square(absv(dx)) + square(absv(dy))) <= square(rad);
	endfunction

	function automatic longint clampv(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic is_live(input int id);
		return id < NUM_IDS && tbl_kind[id] != KIND_EMPTY;
	endfunction

	function automatic logic rect_hits_circle(input int r, input int c);
		longint nx, ny;
		nx = clampv(tbl_x[c], tbl_x[r], tbl_x[r] + tbl_w[r]);
		ny = clampv(tbl_y[c], tbl_y[r], tbl_y[r] + tbl_h[r]);
		return in_radius(tbl_x[c] - nx, tbl_y[c] - ny, tbl_w[c]);
	endfunction

	function automatic void shape_box(input int id, output longint x0, output longint x1,
			output longint y0, output longint y1);
		if (tbl_kind[id] == KIND_RECT) begin
			x0 = tbl_x[id];
			x1 = tbl_x[id] + tbl_w[id];
			y0 = tbl_y[id];
			y1 = tbl_y[id] + tbl_h[id];
		end else begin
			x0 = tbl_x[id] - tbl_w[id];
			x1 = tbl_x[id] + tbl_w[id];
			y0 = tbl_y[id] - tbl_w[id];
			y1 = tbl_y[id] + tbl_w[id];
		end
	endfunction

	function automatic logic shapes_overlap(input int j, input int k);
		if (tbl_kind[j] == KIND_RECT && tbl_kind[k] == KIND_RECT) begin
			return tbl_x[j] <= tbl_x[k] + tbl_w[k] && tbl_x[k] <= tbl_x[j] + tbl_w[j] &&
				tbl_y[j] <= tbl_y[k] + tbl_h[k] && tbl_y[k] <= tbl_y[j] + tbl_h[j];
		end
		if (tbl_kind[j] == KIND_CIRCLE && tbl_kind[k] == KIND_CIRCLE) begin
			return in_radius(tbl_x[j] - tbl_x[k], tbl_y[j] - tbl_y[k], tbl_w[j] + tbl_w[k]);
		end
		return tbl_kind[j] == KIND_RECT ? rect_hits_circle(j, k) : rect_hits_circle(k, j);
	endfunction

	function automatic query_res_t run_table_cmd(input shape_cmd_t c);
		query_res_t r;
		int ja, kb, lo, hi;
		longint a0, a1, b0, b1, c0, c1, d0, d1, qx, qy;
		r = '{status: 1'b0, hit: 1'b0, ox: '0, oy: '0, ow: '0, oh: '0};
		ja = c.id_a;
		kb = c.id_b;
		qx = longint'(c.px);
		qy = longint'(c.py);
		case (c.cmd)
			CMD_WRITE: begin
				if (ja < NUM_IDS) begin
					tbl_kind[ja] = c.kind ? KIND_RECT : KIND_CIRCLE;
					tbl_x[ja] = qx;
					tbl_y[ja] = qy;
					tbl_w[ja] = longint'(c.pw);
					tbl_h[ja] = c.kind ? longint'(c.ph) : 0;
				end
			end
			CMD_DELETE: begin
				lo = ja < kb ? ja : kb;
				hi = ja < kb ? kb : ja;
				for (int i = lo; i <= hi; i++) begin
					if (i < NUM_IDS) begin
						tbl_kind[i] = KIND_EMPTY;
					end
				end
			end
			CMD_OVERLAP: begin
				if (!is_live(ja) || !is_live(kb)) begin
					r.status = 1'b1;
				end else begin
					r.hit = shapes_overlap(ja, kb);
					shape_box(ja, a0, a1, b0, b1);
					shape_box(kb, c0, c1, d0, d1);
					if (c0 < a0) a0 = c0;
					if (c1 > a1) a1 = c1;
					if (d0 < b0) b0 = d0;
					if (d1 > b1) b1 = d1;
					r.ox = 32'(clampv(a0, SAT_LO, SAT_HI));
					r.oy = 32'(clampv(b0, SAT_LO, SAT_HI));
					r.ow = 31'(clampv(a1 - a0, 0, SIZE_MAX));
					r.oh = 31'(clampv(b1 - b0, 0, SIZE_MAX));
				end
			end
			default: begin
				if (!is_live(ja)) begin
					r.status = 1'b1;
				end else if (tbl_kind[ja] == KIND_RECT) begin
					r.hit = tbl_x[ja] <= qx && qx <= tbl_x[ja] + tbl_w[ja] &&
						tbl_y[ja] <= qy && qy <= tbl_y[ja] + tbl_h[ja];
					r.ox = 32'(clampv(tbl_x[ja] + tbl_w[ja] / 2, SAT_LO, SAT_HI));
					r.oy = 32'(clampv(tbl_y[ja] + tbl_h[ja] / 2, SAT_LO, SAT_HI));
				end else begin
					r.hit = in_radius(tbl_x[ja] - qx, tbl_y[ja] - qy, tbl_w[ja]);
					r.ox = 32'(tbl_x[ja]);
					r.oy = 32'(tbl_y[ja]);
				end
			end
		endcase
		return r;
	endfunction

	function automatic shape_cmd_t mk(input cmd_t cmd, input logic [7:0] a, input logic [7:0] b,
			input logic kind, input logic signed [31:0] px, input logic signed [31:0] py,
			input logic [30:0] pw, input logic [30:0] ph);
		shape_cmd_t c;
		c.cmd = cmd;
		c.id_a = a;
		c.id_b = b;
		c.kind = kind;
		c.px = px;
		c.py = py;
		c.pw = pw;
		c.ph = ph;
		return c;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1, 2: return $urandom;
			default: return 32'($urandom_range(0, 32'h200000)) - 32'sh100000;
		endcase
	endfunction

	function automatic logic [30:0] rand_size();
		case ($urandom_range(0, 9))
			0: return 31'($urandom);
			1: return 31'h7fffffff;
			2: return '0;
			default: return 31'($urandom_range(0, 32'hA0000));
		endcase
	endfunction

	function automatic logic [7:0] rand_id();
		return $urandom_range(0, 99) < 85 ? 8'($urandom_range(0, 15)) : 8'($urandom);
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 20;
			default: return 50;
		endcase
	endfunction

	function automatic logic calm_phase();
		return sent_cnt + CALM_TAIL >= total_cmds;
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_responses.push_back(run_table_cmd(cur_cmd));
				sent_cnt = sent_cnt + 1;
				if (sent_cnt % 128 == 0) src_idle_pct = pick_idle_pct();
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_cnt > 0) begin
					s_axis_tvalid <= 1'b0;
					gap_cnt = gap_cnt - 1;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {2'b00, cur_cmd.ph, cur_cmd.pw, cur_cmd.py, cur_cmd.px,
						cur_cmd.id_b, cur_cmd.id_a};
					s_axis_tuser <= {cur_cmd.kind, cur_cmd.cmd};
					if (!calm_phase() && $urandom_range(0, 99) < src_idle_pct) begin
						gap_cnt = $urandom_range(1, 15);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				mon_got.status = m_axis_tuser[0];
				mon_got.hit = m_axis_tdata[0];
				mon_got.ox = m_axis_tdata[32:1];
				mon_got.oy = m_axis_tdata[64:33];
				mon_got.ow = m_axis_tdata[95:65];
				mon_got.oh = m_axis_tdata[126:96];
				if (expected_responses.size() == 0) begin
					if (err_cnt < 10) $display("unexpected result transaction at %0t", $realtime);
					err_cnt = err_cnt + 1;
				end else begin
					mon_want = expected_responses.pop_front();
					if (mon_got.status !== mon_want.status || mon_got.hit !== mon_want.hit ||
							mon_got.ox !== mon_want.ox || mon_got.oy !== mon_want.oy ||
							mon_got.ow !== mon_want.ow || mon_got.oh !== mon_want.oh) begin
						if (err_cnt < 10) begin
							$display("result %0d mismatch: exp st=%b hit=%b x=%h y=%h w=%h h=%h",
								rcv_cnt, mon_want.status, mon_want.hit, mon_want.ox,
								mon_want.oy, mon_want.ow, mon_want.oh);
							$display("result %0d mismatch: got st=%b hit=%b x=%h y=%h w=%h h=%h",
								rcv_cnt, mon_got.status, mon_got.hit, mon_got.ox,
								mon_got.oy, mon_got.ow, mon_got.oh);
						end
						err_cnt = err_cnt + 1;
					end
				end
				rcv_cnt = rcv_cnt + 1;
				if (rcv_cnt % 100 == 0) sink_idle_pct = pick_idle_pct();
			end
			if (stall_cnt > 0) begin
				stall_cnt = stall_cnt - 1;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
				if (!calm_phase() && $urandom_range(0, 99) < sink_idle_pct) begin
					stall_cnt = $urandom_range(1, 15);
				end
			end
			m_axis_tready <= nxt_ready && !hold_rx;
		end
	end

	initial begin
		wait (arst_n === 1'b1 && sent_cnt >= HOLD_AFTER);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#(20_000_000);
		$display("shape_table_collision_query test failed");
		$finish;
	end

	initial begin
		logic [7:0] a, b, t;
		int r;
		foreach (tbl_kind[i]) tbl_kind[i] = KIND_EMPTY;

		// empty table, then touching rectangles, touching circles, mixed pairs
		pending_cmds.push_back(mk(CMD_CONTAINS, 8'd0, 8'd0, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd0, 8'd1, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_WRITE, 8'd0, 8'd0, 1'b1, 32'sd0, 32'sd0,
			31'h10000, 31'h10000));
		pending_cmds.push_back(mk(CMD_WRITE, 8'd1, 8'd0, 1'b1, 32'sh10000, 32'sh10000,
			31'h10000, 31'h10000));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd0, 8'd1, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_WRITE, 8'd2, 8'd0, 1'b0, 32'sh30000, 32'sd0,
			31'h10000, 31'h5555));
		pending_cmds.push_back(mk(CMD_WRITE, 8'd3, 8'd0, 1'b0, 32'sh50000, 32'sd0,
			31'h10000, 31'h0));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd2, 8'd3, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd0, 8'd2, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd2, 8'd1, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_CONTAINS, 8'd0, 8'd0, 1'b0, 32'sh8000, 32'sh8000, '0, '0));
		pending_cmds.push_back(mk(CMD_CONTAINS, 8'd2, 8'd0, 1'b0, 32'sh40000, 32'sd0, '0, '0));
		// extreme corners and sizes, saturating box
		pending_cmds.push_back(mk(CMD_WRITE, 8'd4, 8'hff, 1'b1, 32'sh7fffffff, 32'sh7fffffff,
			31'h7fffffff, 31'h7fffffff));
		pending_cmds.push_back(mk(CMD_WRITE, 8'd5, 8'hff, 1'b0, 32'sh80000000, 32'sh80000000,
			31'h7fffffff, 31'h7fffffff));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd4, 8'd5, 1'b1, 32'sh7fffffff, 32'sh7fffffff,
			31'h7fffffff, 31'h7fffffff));
		pending_cmds.push_back(mk(CMD_CONTAINS, 8'd4, 8'hff, 1'b1, 32'sh7fffffff, 32'sh7fffffff,
			31'h7fffffff, 31'h7fffffff));
		pending_cmds.push_back(mk(CMD_CONTAINS, 8'd5, 8'd0, 1'b0, 32'sh7fffffff, 32'sh7fffffff,
			'0, '0));
		pending_cmds.push_back(mk(CMD_WRITE, 8'd255, 8'd0, 1'b1, -32'sd1, 32'sd0,
			31'h20000, 31'h7fffffff));
		pending_cmds.push_back(mk(CMD_WRITE, 8'd254, 8'd0, 1'b0, 32'sh80000000, 32'sh7fffffff,
			31'h7fffffff, 31'h0));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd255, 8'd254, 1'b0, 32'sd0, 32'sd0, '0, '0));
		// reversed range, then the whole table
		pending_cmds.push_back(mk(CMD_DELETE, 8'd3, 8'd1, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_OVERLAP, 8'd0, 8'd1, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_CONTAINS, 8'd2, 8'd0, 1'b0, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_DELETE, 8'd0, 8'd255, 1'b1, 32'sd0, 32'sd0, '0, '0));
		pending_cmds.push_back(mk(CMD_CONTAINS, 8'd255, 8'd0, 1'b0, 32'sd0, 32'sd0, '0, '0));

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			r = $urandom_range(0, 99);
			a = rand_id();
			b = rand_id();
			if (r < 35) begin
				pending_cmds.push_back(mk(CMD_WRITE, a, 8'($urandom), 1'($urandom),
					rand_coord(), rand_coord(), rand_size(), rand_size()));
			end else if (r < 43) begin
				if ($urandom_range(0, 24) != 0) begin
					b = a + 8'($urandom_range(0, 3));
					if ($urandom_range(0, 1)) begin
						t = a;
						a = b;
						b = t;
					end
				end
				pending_cmds.push_back(mk(CMD_DELETE, a, b, 1'($urandom), $urandom, $urandom,
					31'($urandom), 31'($urandom)));
			end else if (r < 72) begin
				pending_cmds.push_back(mk(CMD_OVERLAP, a, b, 1'($urandom), $urandom, $urandom,
					31'($urandom), 31'($urandom)));
			end else begin
				pending_cmds.push_back(mk(CMD_CONTAINS, a, 8'($urandom), 1'($urandom),
					rand_coord(), rand_coord(), 31'($urandom), 31'($urandom)));
			end
		end
		total_cmds = pending_cmds.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_cmds.size() == 0 && !s_axis_tvalid);
		wait (expected_responses.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && expected_responses.size() == 0) begin
			$display("shape_table_collision_query test passed");
		end else begin
			$display("shape_table_collision_query test failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/stcq_pkg.sv
src/stcq_ram.sv
src/stcq_sqacc.sv
src/stcq_geom.sv
src/shape_table_collision_query.sv
src/stcq_checker.sv
tb/sv/tb.sv
